/* sv/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
package spq_pkg;
    localparam int QueueDepth  = 64;
    localparam int UrgencyBits = 16;
    localparam int TagBits     = 16;
    localparam int AddrBits    = $clog2(QueueDepth);
    localparam int CountBits   = $clog2(QueueDepth + 1);
    localparam int EntryBits   = UrgencyBits + TagBits;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;
endpackage

/* sv/spq_ram.sv */
// Generic simple dual-port RAM with registered read.
module spq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/stable_priority_queue.sv */
// Top level: stable max priority queue over one entry RAM.
//
// An insert, a serve of an empty queue and an insert into a full queue go
// from idle straight to S_DONE, which registers the result strobe. A serve
// of a non-empty queue goes through S_SCAN, S_ADV and, unless the winner is
// the last entry, S_SHIFT before S_DONE: one RAM read a cycle scans the n
// entries for the best one, then the entries behind it are moved down one
// slot, one read and one write per entry through the single RAM. A new beat
// is taken only in idle once the previous result strobe has dropped.
// busy stays high through the result strobe.
// Entries are kept in arrival order, so a strict greater-than during the
// scan leaves the earliest of equal urgencies. The receiver cannot stall.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_op,
    input  logic [UrgencyBits-1:0] i_urgency,
    input  logic [TagBits-1:0]     i_entry_tag,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [TagBits-1:0]     o_served_tag,
    output logic [UrgencyBits-1:0] o_served_urgency
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_DONE  = 5'b01000,
        S_ADV   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [CountBits-1:0]   r_count, n_count;
    logic [CountBits-1:0]   r_idx, n_idx;
    logic [AddrBits-1:0]    r_best, n_best;
    logic [EntryBits-1:0]   r_best_d, n_best_d;
    logic                   r_have, n_have;
    logic                   r_valid, n_valid;
    logic [1:0]             r_status, n_status;
    logic [TagBits-1:0]     r_tag, n_tag;
    logic [UrgencyBits-1:0] r_urg, n_urg;

    logic                   we;
    logic [AddrBits-1:0]    waddr, raddr;
    logic [EntryBits-1:0]   wdata, rdata;
    logic [CountBits-1:0]   rd_idx;
    logic [UrgencyBits-1:0] rd_urg;

    spq_ram #(.Width(EntryBits), .Depth(QueueDepth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rd_urg = rdata[EntryBits-1 -: UrgencyBits];
    // during the scan, data in rdata belongs to index r_idx-1
    assign rd_idx = r_idx - CountBits'(1);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_best   = r_best;
        n_best_d = r_best_d;
        n_have   = r_have;
        n_valid  = 1'b0;
        n_status = r_status;
        n_tag    = r_tag;
        n_urg    = r_urg;
        we       = 1'b0;
        waddr    = r_idx[AddrBits-1:0];
        wdata    = {i_urgency, i_entry_tag};
        raddr    = r_idx[AddrBits-1:0];
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                // no beat is taken while the previous result is on the ports
                if (start && !r_valid) begin
                    n_tag = '0;
                    n_urg = '0;
                    if (i_op == OP_INSERT) begin
                        if (r_count == CountBits'(QueueDepth)) begin
                            n_status = ST_FULL;
                        end else begin
                            we       = 1'b1;
                            waddr    = r_count[AddrBits-1:0];
                            n_count  = r_count + CountBits'(1);
                            n_status = ST_INSERTED;
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = CountBits'(1);
                        n_have  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // compare entry rd_idx against the best so far
                if (!r_have || rd_urg > r_best_d[EntryBits-1 -: UrgencyBits]) begin
                    n_best   = rd_idx[AddrBits-1:0];
                    n_best_d = rdata;
                end
                n_have = 1'b1;
                if (r_idx == r_count) begin
                    n_tag    = (!r_have || rd_urg > r_best_d[EntryBits-1 -: UrgencyBits])
                               ? rdata[TagBits-1:0] : r_best_d[TagBits-1:0];
                    n_urg    = (!r_have || rd_urg > r_best_d[EntryBits-1 -: UrgencyBits])
                               ? rd_urg : r_best_d[EntryBits-1 -: UrgencyBits];
                    n_status = ST_SERVED;
                    n_state  = S_ADV;
                end else begin
                    n_idx = r_idx + CountBits'(1);
                end
            end
            S_ADV: begin
                // start the move-down at the slot after the best entry
                n_idx   = CountBits'(r_best) + CountBits'(1);
                raddr   = n_idx[AddrBits-1:0];
                n_have  = 1'b0;
                n_state = S_SHIFT;
                if (n_idx == r_count) begin
                    n_count = r_count - CountBits'(1);
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // rdata holds entry r_idx; move it to r_idx-1
                we      = 1'b1;
                waddr   = rd_idx[AddrBits-1:0];
                wdata   = rdata;
                n_idx   = r_idx + CountBits'(1);
                raddr   = n_idx[AddrBits-1:0];
                if (n_idx == r_count) begin
                    n_count = r_count - CountBits'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // the read address defaults to r_idx; S_ADV and S_SHIFT read the next index, n_idx
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_have  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_have  <= n_have;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_status <= n_status;
        r_tag    <= n_tag;
        r_urg    <= n_urg;
    end

    assign busy             = (r_state != S_IDLE) || r_valid;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_served_tag     = o_valid ? r_tag : '0;
    assign o_served_urgency = o_valid ? r_urg : '0;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(QueueDepth))
        else $error("entry count above depth");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid)
        else $error("result strobe missing");
    a_serve_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SERVED) |-> $past(r_count, 2) != '0)
        else $error("served from empty queue");
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && busy) |=> (r_count == $past(r_count)) || ($past(r_state) != S_IDLE))
        else $error("beat taken while busy");
`endif
endmodule

/* dv/testbench.sv */
// Testbench for the stable priority queue: directed table, fill past full and drain, then random insert/serve traffic.
module testbench;
    import spq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_op = OP_INSERT;
    logic [UrgencyBits-1:0] i_urgency = '0;
    logic [TagBits-1:0]     i_entry_tag = '0;
    logic                   o_valid;
    logic [1:0]             o_status;
    logic [TagBits-1:0]     o_served_tag;
    logic [UrgencyBits-1:0] o_served_urgency;

    stable_priority_queue uut (.*);

    always #2 i_clk = ~i_clk;

    typedef struct packed {
        t_status                st;
        logic [TagBits-1:0]     tag;
        logic [UrgencyBits-1:0] urg;
    } t_outcome;

    typedef struct {
        logic [UrgencyBits-1:0] urg;
        logic [TagBits-1:0]     tag;
    } t_slot;

    // directed row: op, urgency, tag, whether expected is typed, the expected beat
    typedef struct {
        logic                   op;
        logic [UrgencyBits-1:0] urg;
        logic [TagBits-1:0]     tag;
        bit                     typed;
        t_outcome               want;
    } t_row;

    t_slot    queue_model[$];
    t_outcome pending_outcomes[$];
    int       failures = 0;
    int       idle_cycles = 0;
    bit       calm = 0;

    // Predict one beat's outcome and update the shadow queue.
    function automatic t_outcome serve_or_insert(logic op, logic [UrgencyBits-1:0] urg,
                                                 logic [TagBits-1:0] tag);
        t_outcome r;
        int best;
        r = '{st: ST_INSERTED, tag: '0, urg: '0};
        if (op == OP_INSERT) begin
            if (queue_model.size() >= QueueDepth) r.st = ST_FULL;
            else queue_model.push_back('{urg: urg, tag: tag});
        end else if (queue_model.size() == 0) begin
            r.st = ST_EMPTY;
        end else begin
            best = 0;
            // strict greater keeps the earliest of equal urgencies
            for (int i = 1; i < queue_model.size(); i++)
                if (queue_model[i].urg > queue_model[best].urg) best = i;
            r.st  = ST_SERVED;
            r.tag = queue_model[best].tag;
            r.urg = queue_model[best].urg;
            queue_model.delete(best);
        end
        return r;
    endfunction

    // Drive one beat and hold it until accepted.
    task automatic send_beat(logic op, logic [UrgencyBits-1:0] urg, logic [TagBits-1:0] tag,
                             bit typed, t_outcome want);
        t_outcome p;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 35) @(negedge i_clk);
        start <= 1'b1;
        i_op <= op;
        i_urgency <= urg;
        i_entry_tag <= tag;
        do @(posedge i_clk); while (busy);
        p = serve_or_insert(op, urg, tag);
        if (typed && p != want) begin
            $error("table row disagrees with prediction: %h vs %h", want, p);
            failures++;
        end
        pending_outcomes.push_back(p);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Result check at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_outcome w;
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing expected");
                failures++;
            end else begin
                w = pending_outcomes.pop_front();
                if (o_status !== w.st) begin
                    $error("status expected %0d actual %0d", w.st, o_status);
                    failures++;
                end
                if (o_served_tag !== w.tag) begin
                    $error("served_tag expected %h actual %h", w.tag, o_served_tag);
                    failures++;
                end
                if (o_served_urgency !== w.urg) begin
                    $error("served_urgency expected %h actual %h", w.urg, o_served_urgency);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("stable_priority_queue test failed");
            $finish;
        end
    end

    initial begin
        t_row table_rows[$];
        t_outcome z;
        int mode;
        z = '{st: ST_INSERTED, tag: '0, urg: '0};
        table_rows = '{
            '{OP_SERVE,  16'h1234, 16'h5678, 1, '{ST_EMPTY, 16'h0, 16'h0}},
            '{OP_INSERT, 16'h0000, 16'h0000, 1, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 1, '{ST_SERVED, 16'h0, 16'h0}},
            '{OP_INSERT, 16'hFFFF, 16'hFFFF, 1, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 1, '{ST_SERVED, 16'hFFFF, 16'hFFFF}},
            '{OP_SERVE,  16'h0000, 16'h0000, 1, '{ST_EMPTY, 16'h0, 16'h0}},
            '{OP_INSERT, 16'h0005, 16'h00A1, 0, z},
            '{OP_INSERT, 16'h0009, 16'h00A2, 0, z},
            '{OP_INSERT, 16'h0009, 16'h00A3, 0, z},
            '{OP_INSERT, 16'h0005, 16'h00A4, 0, z},
            '{OP_INSERT, 16'hFFFF, 16'h00A5, 0, z},
            '{OP_SERVE,  16'hFFFF, 16'hFFFF, 0, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 0, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 0, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 0, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 0, z},
            '{OP_SERVE,  16'h0000, 16'h0000, 1, '{ST_EMPTY, 16'h0, 16'h0}}
        };
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_rows[k])
            send_beat(table_rows[k].op, table_rows[k].urg, table_rows[k].tag,
                      table_rows[k].typed, table_rows[k].want);
        // fill past full with urgencies cycling over three values, then drain: full flag and stable order
        for (int k = 0; k < QueueDepth + 2; k++)
            send_beat(OP_INSERT, 16'(16'h0100 + (k % 3)), k[15:0], 0, z);
        while (queue_model.size() > 0) send_beat(OP_SERVE, '0, '0, 0, z);
        // random phases: insert-heavy, balanced, serve-heavy, narrow urgencies
        for (int n = 0; n < 1050; n++) begin
            calm = (n >= 400 && n < 550);
            mode = (n / 150) % 4;
            case (mode)
                0: send_beat($urandom_range(99) < 70 ? OP_INSERT : OP_SERVE,
                             16'($urandom), 16'($urandom), 0, z);
                1: send_beat(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 0, z);
                2: send_beat($urandom_range(99) < 30 ? OP_INSERT : OP_SERVE,
                             16'($urandom), 16'($urandom), 0, z);
                default: send_beat($urandom_range(99) < 55 ? OP_INSERT : OP_SERVE,
                                   16'($urandom_range(3)), 16'($urandom), 0, z);
            endcase
        end
        calm = 0;
        while (pending_outcomes.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) $display("stable_priority_queue test passed");
        else $display("stable_priority_queue test failed");
        $finish;
    end
endmodule
